// ===== sv/jpkt_pkg.sv =====
// Shared types, codes and constants for the JSON path key tokeniser.
`timescale 1ns / 1ps

package jpkt_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_RES     = 3;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TEND = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7a;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5a;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  typedef struct packed {
    logic [7:0] path_char;
    logic       path_start;
    logic       path_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key_byte;
    logic       last_of_item;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key_byte;
  } res_t;

  // One input character's worth of results, count is 1..MAX_RES
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MAX_RES-1:0]     res;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/jpkt_front.sv =====
// Front end: parse-mode state machine, turns each character into a queue entry.
`timescale 1ns / 1ps

module jpkt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  jpkt_pkg::in_item_t  in_data,
  output logic                push,
  output jpkt_pkg::entry_t    push_entry
);

  typedef enum logic [10:0] {
    M_ROOT   = 11'b00000000001,
    M_SEP    = 11'b00000000010,
    M_DOT1   = 11'b00000000100,
    M_DOTRUN = 11'b00000001000,
    M_BROPEN = 11'b00000010000,
    M_UNQ    = 11'b00000100000,
    M_Q1     = 11'b00001000000,
    M_QRUN   = 11'b00010000000,
    M_QESC   = 11'b00100000000,
    M_QCLOSE = 11'b01000000000,
    M_ERR    = 11'b10000000000
  } mode_t;

  mode_t mode_r, mode_nxt;
  mode_t m, nm;
  logic  fail, e_byte, e_tend;
  logic  [1:0] cnt;
  jpkt_pkg::res_t [jpkt_pkg::MAX_RES-1:0] res;
  logic  [7:0] c;
  logic  accept;

  function automatic logic is_unq(input logic [7:0] ch);
    is_unq = (ch inside {[jpkt_pkg::CH_LC_A:jpkt_pkg::CH_LC_Z],
                         [jpkt_pkg::CH_UC_A:jpkt_pkg::CH_UC_Z],
                         [jpkt_pkg::CH_DIG_0:jpkt_pkg::CH_DIG_9],
                         jpkt_pkg::CH_USCORE, jpkt_pkg::CH_STAR});
  endfunction

  function automatic logic is_dotc(input logic [7:0] ch);
    is_dotc = is_unq(ch) || ch == jpkt_pkg::CH_COLON || ch == jpkt_pkg::CH_DASH;
  endfunction

  assign c      = in_data.path_char;
  assign accept = in_valid && !in_stall;

  always_comb begin
    m      = in_data.path_start ? M_ROOT : mode_r;
    nm     = M_ERR;
    fail   = 1'b0;
    e_byte = 1'b0;
    e_tend = 1'b0;
    case (m)
      M_ROOT: begin
        if (c == jpkt_pkg::CH_DOLLAR) nm = M_SEP;
        else fail = 1'b1;
      end
      M_SEP: begin
        if (c == jpkt_pkg::CH_DOT) nm = M_DOT1;
        else if (c == jpkt_pkg::CH_LBRACK) nm = M_BROPEN;
        else fail = 1'b1;
      end
      M_DOT1: begin
        if (is_dotc(c)) begin
          e_byte = 1'b1;
          nm     = M_DOTRUN;
        end else fail = 1'b1;
      end
      M_DOTRUN: begin
        if (is_dotc(c)) begin
          e_byte = 1'b1;
          nm     = M_DOTRUN;
        end else if (c == jpkt_pkg::CH_DOT) begin
          e_tend = 1'b1;
          nm     = M_DOT1;
        end else if (c == jpkt_pkg::CH_LBRACK) begin
          e_tend = 1'b1;
          nm     = M_BROPEN;
        end else fail = 1'b1;
      end
      M_BROPEN: begin
        if (c == jpkt_pkg::CH_QUOTE) nm = M_Q1;
        else if (is_unq(c)) begin
          e_byte = 1'b1;
          nm     = M_UNQ;
        end else fail = 1'b1;
      end
      M_UNQ: begin
        if (is_unq(c)) begin
          e_byte = 1'b1;
          nm     = M_UNQ;
        end else if (c == jpkt_pkg::CH_RBRACK) begin
          e_tend = 1'b1;
          nm     = M_SEP;
        end else fail = 1'b1;
      end
      M_Q1: begin
        if (c == jpkt_pkg::CH_BSLASH) nm = M_QESC;
        else if (c == jpkt_pkg::CH_QUOTE) fail = 1'b1;
        else begin
          e_byte = 1'b1;
          nm     = M_QRUN;
        end
      end
      M_QRUN: begin
        if (c == jpkt_pkg::CH_BSLASH) nm = M_QESC;
        else if (c == jpkt_pkg::CH_QUOTE) nm = M_QCLOSE;
        else begin
          e_byte = 1'b1;
          nm     = M_QRUN;
        end
      end
      M_QESC: begin
        if (c == jpkt_pkg::CH_QUOTE || c == jpkt_pkg::CH_BSLASH) begin
          e_byte = 1'b1;
          nm     = M_QRUN;
        end else fail = 1'b1;
      end
      M_QCLOSE: begin
        if (c == jpkt_pkg::CH_RBRACK) begin
          e_tend = 1'b1;
          nm     = M_SEP;
        end else fail = 1'b1;
      end
      default: begin
        nm = M_ERR;
      end
    endcase
    if (fail) nm = M_ERR;
  end

  // Pack the results in order; at most three can arise from one character
  always_comb begin
    cnt = 2'd0;
    res = '0;
    if (e_byte) begin
      res[cnt] = '{kind: jpkt_pkg::KIND_BYTE, key_byte: c};
      cnt      = cnt + 2'd1;
    end
    if (e_tend) begin
      res[cnt] = '{kind: jpkt_pkg::KIND_TEND, key_byte: 8'd0};
      cnt      = cnt + 2'd1;
    end
    if (fail) begin
      res[cnt] = '{kind: jpkt_pkg::KIND_ERR, key_byte: 8'd0};
      cnt      = cnt + 2'd1;
    end
    if (in_data.path_end) begin
      if (nm == M_ERR) begin
        if (!fail) begin
          res[cnt] = '{kind: jpkt_pkg::KIND_ERR, key_byte: 8'd0};
          cnt      = cnt + 2'd1;
        end
      end else if (nm == M_SEP) begin
        res[cnt] = '{kind: jpkt_pkg::KIND_DONE, key_byte: 8'd0};
        cnt      = cnt + 2'd1;
      end else if (nm == M_DOTRUN) begin
        res[cnt] = '{kind: jpkt_pkg::KIND_TEND, key_byte: 8'd0};
        cnt      = cnt + 2'd1;
        res[cnt] = '{kind: jpkt_pkg::KIND_DONE, key_byte: 8'd0};
        cnt      = cnt + 2'd1;
      end else begin
        res[cnt] = '{kind: jpkt_pkg::KIND_ERR, key_byte: 8'd0};
        cnt      = cnt + 2'd1;
      end
    end
  end

  assign mode_nxt       = in_data.path_end ? M_ROOT : nm;
  assign push           = accept && (cnt != 2'd0);
  assign push_entry.cnt = cnt;
  assign push_entry.res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_ROOT;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ===== sv/jpkt_queue.sv =====
// Short entry queue between the parser front end and the result serialiser.
`timescale 1ns / 1ps

module jpkt_queue #(
  parameter int DEPTH = jpkt_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  jpkt_pkg::entry_t      push_entry,
  input  logic                  pop,
  output jpkt_pkg::entry_t      pop_entry,
  output jpkt_pkg::q_status_t   status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jpkt_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(DEPTH));
  assign pop_entry    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/jpkt_back.sv =====
// Back end: holds one queue entry and emits its results one beat at a time.
`timescale 1ns / 1ps

module jpkt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jpkt_pkg::entry_t     pop_entry,
  input  jpkt_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output jpkt_pkg::out_item_t  out_data
);

  jpkt_pkg::entry_t cur_r;
  logic       valid_r;
  logic [1:0] idx_r, idx_nxt;
  logic       fire, last;

  assign last    = (idx_r == cur_r.cnt - 2'd1);
  assign fire    = valid_r && !out_stall;
  assign pop     = !q_status.empty && (!valid_r || (fire && last));
  assign idx_nxt = idx_r + 2'd1;

  assign out_valid             = valid_r;
  assign out_data.kind         = cur_r.res[idx_r].kind;
  assign out_data.key_byte     = cur_r.res[idx_r].key_byte;
  assign out_data.last_of_item = last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (pop) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (fire) begin
      if (last) valid_r <= 1'b0;
      else      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== sv/json_path_key_tokenizer_core.sv =====
// Top level of the JSON path key tokeniser: front end, entry queue, back end.
`timescale 1ns / 1ps

// Input channel: one path character per beat (in_valid / in_stall), with
//   path_start on the first character of a path and path_end on the last.
// Output channel: one result per beat (out_valid / out_stall): key byte,
//   token end, done or error; last_of_item marks the final result of a
//   character. Characters that give no result produce no beat.
// Throughput: one character per cycle while the queue is not full, set by the
//   combinational parse-mode lookup in the front end; a character that gives n
//   results holds the output for n beats, and the queue absorbs the difference.
// Flow: the results of a character are written into the queue when it is
//   accepted and then loaded into the back-end holding register once that
//   register is free; the first result is offered from there.
// Stall: a stalled output holds its beat; once the queue is full, in_stall
//   rises and the front end waits.
// Reset: rst_n low, synchronous; parse mode returns to expecting the root
//   character and the queue and output empty.
module json_path_key_tokenizer_core #(
  parameter int QUEUE_DEPTH = jpkt_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  jpkt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output jpkt_pkg::out_item_t  out_data
);

  logic                push, pop;
  jpkt_pkg::entry_t    push_entry, pop_entry;
  jpkt_pkg::q_status_t q_status;

  assign in_stall = q_status.full;

  jpkt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_entry (push_entry)
  );

  jpkt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  jpkt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_entry (pop_entry),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("entry pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("entry popped from empty queue");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_entry.cnt != 2'd0))
    else $error("queue entry without results");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output or stall active after reset");
`endif

endmodule

// ===== test/json_path_key_tokenizer_core_tb.sv =====
// Self-checking testbench for the JSON path key tokeniser core.
`timescale 1ns / 1ps

module json_path_key_tokenizer_core_tb;
  import jpkt_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int CALM_TAIL    = 25;
  localparam int HOLD_AT      = 50;
  localparam int HOLD_LEN     = 40;
  localparam int DRAIN_PATH   = 12;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [3:0] {
    PM_ROOT, PM_SEP, PM_DOT1, PM_DOTRUN, PM_BROPEN, PM_UNQ,
    PM_Q1, PM_QRUN, PM_QESC, PM_QCLOSE, PM_ERR
  } parse_mode_e;

  typedef struct packed {
    in_item_t item;
    logic     drain;
  } char_beat_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  char_beat_t  pending_chars [$];
  logic [7:0]  path_buf [$];
  out_item_t   expected_results [$];
  out_item_t   char_results [$];
  parse_mode_e mode_q = PM_ROOT;

  bit calm = 1'b0;
  int tx_gap;
  int rx_gap;
  int hold_left;
  bit hold_done;
  int total_chars;
  int chars_accepted;
  int paths_built;
  int fail_count;
  int kind_seen [4];

  json_path_key_tokenizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_alnum_char(logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9);
  endfunction

  function automatic bit is_bracket_key_char(logic [7:0] c);
    return c == CH_USCORE || c == CH_STAR || is_alnum_char(c);
  endfunction

  function automatic bit is_dot_key_char(logic [7:0] c);
    return c == CH_COLON || c == CH_DASH || is_bracket_key_char(c);
  endfunction

  function automatic void add_result(logic [1:0] k, logic [7:0] b);
    out_item_t r;
    r.kind = k;
    r.key_byte = b;
    r.last_of_item = 1'b0;
    char_results.push_back(r);
  endfunction

  // Advances the parse mode by one character and queues the results it gives
  function automatic void tokenise_char(in_item_t it);
    logic [7:0]  c;
    parse_mode_e m;
    parse_mode_e nm;
    bit          fail;
    out_item_t   r;
    int          n;
    c = it.path_char;
    m = mode_q;
    if (it.path_start) m = PM_ROOT;
    nm = PM_ERR;
    fail = 1'b0;
    case (m)
      PM_ROOT: begin
        if (c == CH_DOLLAR) nm = PM_SEP;
        else fail = 1'b1;
      end
      PM_SEP: begin
        if (c == CH_DOT) nm = PM_DOT1;
        else if (c == CH_LBRACK) nm = PM_BROPEN;
        else fail = 1'b1;
      end
      PM_DOT1: begin
        if (is_dot_key_char(c)) begin
          add_result(KIND_BYTE, c);
          nm = PM_DOTRUN;
        end else begin
          fail = 1'b1;
        end
      end
      PM_DOTRUN: begin
        if (is_dot_key_char(c)) begin
          add_result(KIND_BYTE, c);
          nm = PM_DOTRUN;
        end else if (c == CH_DOT) begin
          add_result(KIND_TEND, 8'h00);
          nm = PM_DOT1;
        end else if (c == CH_LBRACK) begin
          add_result(KIND_TEND, 8'h00);
          nm = PM_BROPEN;
        end else begin
          fail = 1'b1;
        end
      end
      PM_BROPEN: begin
        if (c == CH_QUOTE) begin
          nm = PM_Q1;
        end else if (is_bracket_key_char(c)) begin
          add_result(KIND_BYTE, c);
          nm = PM_UNQ;
        end else begin
          fail = 1'b1;
        end
      end
      PM_UNQ: begin
        if (is_bracket_key_char(c)) begin
          add_result(KIND_BYTE, c);
          nm = PM_UNQ;
        end else if (c == CH_RBRACK) begin
          add_result(KIND_TEND, 8'h00);
          nm = PM_SEP;
        end else begin
          fail = 1'b1;
        end
      end
      PM_Q1: begin
        if (c == CH_BSLASH) begin
          nm = PM_QESC;
        end else if (c == CH_QUOTE) begin
          fail = 1'b1;
        end else begin
          add_result(KIND_BYTE, c);
          nm = PM_QRUN;
        end
      end
      PM_QRUN: begin
        if (c == CH_BSLASH) begin
          nm = PM_QESC;
        end else if (c == CH_QUOTE) begin
          nm = PM_QCLOSE;
        end else begin
          add_result(KIND_BYTE, c);
          nm = PM_QRUN;
        end
      end
      PM_QESC: begin
        if (c == CH_QUOTE || c == CH_BSLASH) begin
          add_result(KIND_BYTE, c);
          nm = PM_QRUN;
        end else begin
          fail = 1'b1;
        end
      end
      PM_QCLOSE: begin
        if (c == CH_RBRACK) begin
          add_result(KIND_TEND, 8'h00);
          nm = PM_SEP;
        end else begin
          fail = 1'b1;
        end
      end
      default: nm = PM_ERR;
    endcase

    if (fail) begin
      add_result(KIND_ERR, 8'h00);
      nm = PM_ERR;
    end

    if (it.path_end) begin
      if (nm == PM_ERR) begin
        if (!fail) add_result(KIND_ERR, 8'h00);
      end else if (nm == PM_SEP) begin
        add_result(KIND_DONE, 8'h00);
      end else if (nm == PM_DOTRUN) begin
        add_result(KIND_TEND, 8'h00);
        add_result(KIND_DONE, 8'h00);
      end else begin
        add_result(KIND_ERR, 8'h00);
      end
      nm = PM_ROOT;
    end

    mode_q = nm;
    n = char_results.size();
    for (int i = 0; i < n; i++) begin
      r = char_results[i];
      r.last_of_item = (i == n - 1);
      expected_results.push_back(r);
    end
    char_results.delete();
  endfunction

  function automatic logic [7:0] rand_key_char(bit dot_key);
    int r;
    r = $urandom_range(0, dot_key ? 4 : 3);
    case (r)
      0: return 8'(CH_LC_A + $urandom_range(0, 25));
      1: return 8'(CH_UC_A + $urandom_range(0, 25));
      2: return 8'(CH_DIG_0 + $urandom_range(0, 9));
      3: return $urandom_range(0, 1) ? CH_USCORE : CH_STAR;
      default: return $urandom_range(0, 1) ? CH_COLON : CH_DASH;
    endcase
  endfunction

  function automatic logic [7:0] rand_quoted_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
  endtask

  task automatic flush_path(input bit mark_start, input bit mark_end, input bit drain,
                            input int restart_at);
    char_beat_t b;
    for (int i = 0; i < path_buf.size(); i++) begin
      b.item.path_char  = path_buf[i];
      b.item.path_start = (i == 0 && mark_start) || i == restart_at;
      b.item.path_end   = mark_end && i == path_buf.size() - 1;
      b.drain           = drain && i == 0;
      pending_chars.push_back(b);
    end
    total_chars += path_buf.size();
    paths_built++;
    path_buf.delete();
  endtask

  // Driver: one character beat at a time, predicting on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      mode_q = PM_ROOT;
      tx_gap = 0;
    end else begin
      calm = pending_chars.size() < CALM_TAIL;
      if (in_valid && !in_stall) begin
        tokenise_char(in_data);
        chars_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() == 0 ||
                     (pending_chars[0].drain && expected_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_chars[0].item;
          in_valid <= 1'b1;
          void'(pending_chars.pop_front());
        end
      end
    end
  end

  // Receiver stall: random bursts plus one long hold to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && chars_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      kind_seen[out_data.kind]++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat, expected none, actual kind %0d byte %02h last %0b",
                 $time, out_data.kind, out_data.key_byte, out_data.last_of_item);
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind) begin
          fail_count++;
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, out_data.kind);
        end
        if (out_data.key_byte !== want.key_byte) begin
          fail_count++;
          $display("%0t: key_byte mismatch, expected %02h, actual %02h",
                   $time, want.key_byte, out_data.key_byte);
        end
        if (out_data.last_of_item !== want.last_of_item) begin
          fail_count++;
          $display("%0t: last_of_item mismatch, expected %0b, actual %0b",
                   $time, want.last_of_item, out_data.last_of_item);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int  directed_chars;
    int  nseg;
    int  len;
    int  flaw;
    int  restart;
    int  keep;
    int  e;
    bit  mark_start;
    bit  mark_end;
    bit  prev_ended;

    // Directed paths
    load_text("$");
    flush_path(1'b1, 1'b1, 1'b0, -1);
    load_text("$.Z:-[9_*]");
    flush_path(1'b1, 1'b1, 1'b0, -1);
    load_text("$[\"\\\\\"]");
    flush_path(1'b1, 1'b1, 1'b0, -1);
    // error, ignored byte, restart mid-path, error found on the final byte
    path_buf.push_back(8'h00);
    path_buf.push_back(8'hff);
    path_buf.push_back(CH_DOLLAR);
    path_buf.push_back(8'h80);
    flush_path(1'b1, 1'b1, 1'b0, 2);
    // new path without a start marker, then an open dot key at the end
    load_text("$");
    flush_path(1'b0, 1'b1, 1'b0, -1);
    load_text("$.a");
    flush_path(1'b1, 1'b1, 1'b0, -1);
    directed_chars = total_chars;

    prev_ended = 1'b1;
    while (total_chars < directed_chars + RANDOM_ITEMS) begin
      path_buf.push_back(CH_DOLLAR);
      nseg = $urandom_range(0, 3);
      repeat (nseg) begin
        case ($urandom_range(0, 2))
          0: begin
            path_buf.push_back(CH_DOT);
            repeat ($urandom_range(1, 4)) path_buf.push_back(rand_key_char(1'b1));
          end
          1: begin
            path_buf.push_back(CH_LBRACK);
            repeat ($urandom_range(1, 3)) path_buf.push_back(rand_key_char(1'b0));
            path_buf.push_back(CH_RBRACK);
          end
          default: begin
            path_buf.push_back(CH_LBRACK);
            path_buf.push_back(CH_QUOTE);
            len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
            repeat (len) begin
              if ($urandom_range(0, 3) == 0) begin
                path_buf.push_back(CH_BSLASH);
                e = $urandom_range(0, 4);
                path_buf.push_back(e == 0 ? CH_QUOTE : e == 1 ? CH_BSLASH :
                                   e == 2 ? CH_QUOTE : e == 3 ? CH_BSLASH :
                                   rand_quoted_char());
              end else begin
                path_buf.push_back(rand_quoted_char());
              end
            end
            path_buf.push_back(CH_QUOTE);
            path_buf.push_back(CH_RBRACK);
          end
        endcase
      end

      mark_end = 1'b1;
      restart = -1;
      flaw = $urandom_range(0, 9);
      case (flaw)
        5: path_buf[$urandom_range(0, path_buf.size() - 1)] = 8'($urandom_range(0, 255));
        6: begin
          keep = $urandom_range(1, path_buf.size());
          while (path_buf.size() > keep) void'(path_buf.pop_back());
        end
        7: begin
          path_buf.delete();
          repeat ($urandom_range(1, 6)) path_buf.push_back(8'($urandom_range(0, 255)));
        end
        8: mark_end = 1'b0;
        9: if (path_buf.size() > 1) restart = $urandom_range(1, path_buf.size() - 1);
        default: ;
      endcase
      mark_start = !(prev_ended && $urandom_range(0, 3) == 0);
      flush_path(mark_start, mark_end, paths_built == DRAIN_PATH, restart);
      prev_ended = mark_end;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_accepted != total_chars) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d paths, %0d characters: %0d key bytes, %0d token ends,",
             paths_built, total_chars, kind_seen[KIND_BYTE], kind_seen[KIND_TEND]);
    $display("%0d done, %0d errors, a %0d-cycle output hold and a full drain before one path",
             kind_seen[KIND_DONE], kind_seen[KIND_ERR], HOLD_LEN);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
